// ===== src/ccsd_pkg.sv =====
// Shared types, codes and helpers for the CBOR certificate stream decoder.
// No dependencies.
package ccsd_pkg;

    localparam int KEY_BYTES = 64;

    // CBOR major types
    localparam logic [2:0] MAJ_UINT  = 3'd0;
    localparam logic [2:0] MAJ_BSTR  = 3'd2;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;

    // additional info: first code that announces argument bytes after the head
    localparam logic [4:0] INFO_ARG1 = 5'd24;

    localparam logic [63:0] ARRAY_LEN = 64'd8;

    // element being decoded
    localparam logic [3:0] PH_ARRAY    = 4'd0;
    localparam logic [3:0] PH_TYPE     = 4'd1;
    localparam logic [3:0] PH_SERIAL   = 4'd2;
    localparam logic [3:0] PH_SUBJ     = 4'd3;
    localparam logic [3:0] PH_ISS      = 4'd4;
    localparam logic [3:0] PH_FROM     = 4'd5;
    localparam logic [3:0] PH_DURATION = 4'd6;
    localparam logic [3:0] PH_USAGE    = 4'd7;
    localparam logic [3:0] PH_KEY      = 4'd8;

    // field codes of a result word
    localparam logic [3:0] FC_TYPE      = 4'd0;
    localparam logic [3:0] FC_SERIAL    = 4'd1;
    localparam logic [3:0] FC_SUBJ_LEN  = 4'd2;
    localparam logic [3:0] FC_SUBJ_BYTE = 4'd3;
    localparam logic [3:0] FC_ISS_LEN   = 4'd4;
    localparam logic [3:0] FC_ISS_BYTE  = 4'd5;
    localparam logic [3:0] FC_FROM      = 4'd6;
    localparam logic [3:0] FC_DURATION  = 4'd7;
    localparam logic [3:0] FC_USAGE     = 4'd8;
    localparam logic [3:0] FC_KEY_BYTE  = 4'd9;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAJOR = 3'd1;
    localparam logic [2:0] ST_BAD_COUNT = 3'd2;
    localparam logic [2:0] ST_RSVD_INFO = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;
    localparam logic [2:0] ST_ID_LONG   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_item;

    typedef struct packed {
        logic [3:0]  field_code;
        logic [63:0] int_value;
        logic [7:0]  string_byte;
        logic [5:0]  byte_index;
        logic [2:0]  status;
        logic        last_of_cert;
    } t_result;

    function automatic logic [3:0] phase_code(input logic [3:0] phase, input logic in_string);
        logic [3:0] code;
        case (phase)
            PH_ARRAY:    code = FC_TYPE;
            PH_TYPE:     code = FC_TYPE;
            PH_SERIAL:   code = FC_SERIAL;
            PH_SUBJ:     code = in_string ? FC_SUBJ_BYTE : FC_SUBJ_LEN;
            PH_ISS:      code = in_string ? FC_ISS_BYTE : FC_ISS_LEN;
            PH_FROM:     code = FC_FROM;
            PH_DURATION: code = FC_DURATION;
            PH_USAGE:    code = FC_USAGE;
            default:     code = FC_KEY_BYTE;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] major_for_phase(input logic [3:0] phase);
        logic [2:0] maj;
        if (phase == PH_ARRAY) begin
            maj = MAJ_ARRAY;
        end else if (phase inside {PH_SUBJ, PH_ISS, PH_KEY}) begin
            maj = MAJ_BSTR;
        end else begin
            maj = MAJ_UINT;
        end
        return maj;
    endfunction

endpackage

// ===== src/ccsd_stream_if.sv =====
// Valid/ready stream channel carrying one payload word per handshake.
// Payload type is supplied by the instantiating module.
interface ccsd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ccsd_core.sv =====
// Decoder state and per-byte step logic: head parsing, field sequencing, checks.
// Depends on ccsd_pkg.
module ccsd_core
    import ccsd_pkg::*;
#(
    parameter int MAX_ID_BYTES = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [3:0]  r_phase,    n_phase;
    logic [3:0]  r_head_left, n_head_left;
    logic [63:0] r_acc,      n_acc;
    logic [6:0]  r_str_left, n_str_left;
    logic [5:0]  r_str_pos,  n_str_pos;
    logic        r_done,     n_done;
    logic        r_err,      n_err;

    always_comb begin
        logic [7:0] b;
        logic [2:0] major;
        logic [4:0] info;
        logic       do_fin;
        logic [3:0] cur_code;

        b        = i_item.data_byte;
        major    = b[7:5];
        info     = b[4:0];
        do_fin   = 1'b0;
        cur_code = phase_code(r_phase, r_str_left != 7'd0);

        n_phase     = r_phase;
        n_head_left = r_head_left;
        n_acc       = r_acc;
        n_str_left  = r_str_left;
        n_str_pos   = r_str_pos;
        n_done      = r_done;
        n_err       = r_err;

        o_res_valid = 1'b0;
        o_res       = '0;

        if (!(r_done || r_err)) begin
            if (r_str_left != 7'd0) begin
                o_res_valid       = 1'b1;
                o_res.field_code  = cur_code;
                o_res.string_byte = b;
                o_res.byte_index  = r_str_pos;
                n_str_pos         = r_str_pos + 6'd1;
                n_str_left        = r_str_left - 7'd1;
                if (r_str_left == 7'd1) begin
                    if (r_phase >= PH_KEY) begin
                        n_done             = 1'b1;
                        o_res.last_of_cert = 1'b1;
                    end else begin
                        n_phase = r_phase + 4'd1;
                    end
                end
            end else if (r_head_left != 4'd0) begin
                n_acc       = {r_acc[55:0], b};
                n_head_left = r_head_left - 4'd1;
                do_fin      = (r_head_left == 4'd1);
            end else if (major != major_for_phase(r_phase)) begin
                o_res_valid        = 1'b1;
                o_res.field_code   = cur_code;
                o_res.status       = ST_BAD_MAJOR;
                o_res.last_of_cert = 1'b1;
                n_err              = 1'b1;
            end else if (info < INFO_ARG1) begin
                n_acc  = {59'd0, info};
                do_fin = 1'b1;
            end else if (info[4:2] == INFO_ARG1[4:2]) begin
                // 1, 2, 4 or 8 argument bytes follow
                n_acc       = '0;
                n_head_left = 4'd1 << info[1:0];
            end else begin
                o_res_valid        = 1'b1;
                o_res.field_code   = cur_code;
                o_res.status       = ST_RSVD_INFO;
                o_res.last_of_cert = 1'b1;
                n_err              = 1'b1;
            end

            if (do_fin) begin
                case (r_phase)
                    PH_ARRAY: begin
                        if (n_acc != ARRAY_LEN) begin
                            o_res_valid        = 1'b1;
                            o_res.field_code   = cur_code;
                            o_res.status       = ST_BAD_COUNT;
                            o_res.last_of_cert = 1'b1;
                            n_err              = 1'b1;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_TYPE, PH_USAGE: begin
                        o_res_valid      = 1'b1;
                        o_res.field_code = cur_code;
                        o_res.int_value  = {56'd0, n_acc[7:0]};
                        n_phase          = r_phase + 4'd1;
                    end
                    PH_SERIAL, PH_FROM, PH_DURATION: begin
                        o_res_valid      = 1'b1;
                        o_res.field_code = cur_code;
                        o_res.int_value  = n_acc;
                        n_phase          = r_phase + 4'd1;
                    end
                    PH_SUBJ, PH_ISS: begin
                        o_res_valid      = 1'b1;
                        o_res.field_code = cur_code;
                        if (n_acc > 64'(MAX_ID_BYTES)) begin
                            o_res.status       = ST_ID_LONG;
                            o_res.last_of_cert = 1'b1;
                            n_err              = 1'b1;
                        end else begin
                            o_res.int_value = n_acc;
                            if (n_acc == 64'd0) begin
                                // empty id: move straight on
                                n_phase = r_phase + 4'd1;
                            end else begin
                                n_str_left = n_acc[6:0];
                                n_str_pos  = '0;
                            end
                        end
                    end
                    default: begin
                        if (n_acc != 64'(KEY_BYTES)) begin
                            o_res_valid        = 1'b1;
                            o_res.field_code   = cur_code;
                            o_res.status       = ST_BAD_COUNT;
                            o_res.last_of_cert = 1'b1;
                            n_err              = 1'b1;
                        end else begin
                            n_str_left = 7'(KEY_BYTES);
                            n_str_pos  = '0;
                        end
                    end
                endcase
            end
        end

        if (i_item.end_of_buffer) begin
            // replace the result when the buffer ends mid-certificate
            if (!n_done && !n_err) begin
                o_res_valid        = 1'b1;
                o_res              = '0;
                o_res.field_code   = phase_code(n_phase, n_str_left != 7'd0);
                o_res.status       = ST_TRUNC;
                o_res.last_of_cert = 1'b1;
            end
            n_phase     = PH_ARRAY;
            n_head_left = '0;
            n_acc       = '0;
            n_str_left  = '0;
            n_str_pos   = '0;
            n_done      = 1'b0;
            n_err       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ARRAY;
            r_head_left <= '0;
            r_acc       <= '0;
            r_str_left  <= '0;
            r_str_pos   <= '0;
            r_done      <= 1'b0;
            r_err       <= 1'b0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_head_left <= n_head_left;
            r_acc       <= n_acc;
            r_str_left  <= n_str_left;
            r_str_pos   <= n_str_pos;
            r_done      <= n_done;
            r_err       <= n_err;
        end
    end

endmodule

// ===== src/cbor_cert_stream_decoder_top.sv =====
// CBOR certificate stream decoder: one encoded byte in per word, zero or one result out.
// Latency: a result is on o_out the cycle after its byte is accepted, unless an
// earlier word still waits there; then it follows that word from the skid register.
// Throughput: one byte per cycle; input stalls only while both the output
// register and the skid register hold results.
// Reset (synchronous, active low) returns the decoder to the array head and
// empties the output buffer.
module cbor_cert_stream_decoder_top
    import ccsd_pkg::*;
#(
    parameter int MAX_ID_BYTES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccsd_stream_if.sink   i_in,
    ccsd_stream_if.source o_out
);

    logic    take;
    logic    res_valid;
    t_result res;
    logic    push;
    logic    pop;

    logic    r_out_v;
    t_result r_out;
    logic    r_skid_v;
    t_result r_skid;

    ccsd_core #(
        .MAX_ID_BYTES(MAX_ID_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (i_in.payload),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign i_in.ready    = !r_skid_v;
    assign take          = i_in.valid && i_in.ready;
    assign push          = take && res_valid;
    assign pop           = r_out_v && o_out.ready;
    assign o_out.valid   = r_out_v;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            // skid word goes first; input is held off while it is full
            r_out_v  <= r_skid_v || push;
            r_skid_v <= 1'b0;
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            r_out <= r_skid_v ? r_skid : res;
        end
        if (push && r_out_v && !pop) begin
            r_skid <= res;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a word while output register is empty");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.status != ST_OK) |-> r_out.last_of_cert)
        else $error("error result not marked last_of_cert");

    a_byte_no_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.field_code == FC_SUBJ_BYTE || r_out.field_code == FC_ISS_BYTE
            || r_out.field_code == FC_KEY_BYTE)) |-> (r_out.int_value == 64'd0))
        else $error("string byte result carries an integer value");
`endif

endmodule
